FILE: rtl/core/tbq_pkg.sv
// Shared constants, codes and types for the trackball drag quaternion block.
// No dependencies; every other file of the block imports it.

package tbq_pkg;

  // Default sizes
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int OUT_FRAC       = 14;
  localparam int QUAT_ONE       = 16384;

  // Register reset values
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Event codes
  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_MOVE    = 2'd2;

  // Register indexes (word address bit 2)
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,   // wait for a job
    ST_SX,     // divide: sphere x
    ST_SY,     // divide: sphere y
    ST_S2,     // mac: x*x + y*y
    ST_SZ,     // sqrt: z or rim length
    ST_SNX,    // divide: rim-projected x
    ST_SNY,    // divide: rim-projected y
    ST_DOT,    // mac: a . b
    ST_CROSS,  // mac: one cross component
    ST_NORM,   // mac: |c|^2
    ST_NSQ,    // sqrt: |c|
    ST_SIN,    // sqrt: sin half angle
    ST_COS,    // sqrt: cos half angle
    ST_VEC,    // mac: s * c[k]
    ST_VDIV,   // divide: s * c[k] / n
    ST_OUT     // hand result to output register
  } back_state_t;

endpackage

FILE: rtl/core/tbq_if.sv
// Handshake channel interfaces: pointer events in, quaternions out.
// Depends on tbq_pkg.

interface tbq_evt_if import tbq_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  modport source (output valid, operation, pos_x, pos_y, input ready);
  modport sink   (input valid, operation, pos_x, pos_y, output ready);
endinterface

interface tbq_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

FILE: rtl/core/tbq_queue.sv
// Small register FIFO carrying drag jobs from the front end to the back end.
// Depends on tbq_pkg.

module tbq_queue import tbq_pkg::*; #(
  parameter int WORD_BITS = 48,
  parameter int DEPTH     = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WORD_BITS-1:0] push_data,
  output logic                 full,
  input  logic                 pop,
  output logic [WORD_BITS-1:0] pop_data,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: rtl/core/tbq_front.sv
// Front end: accepts pointer events, tracks the drag, queues drag jobs.
// Depends on tbq_pkg and tbq_evt_if.

module tbq_front import tbq_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [COORD_BITS-1:0]   width_eff,
  input  logic [COORD_BITS-1:0]   height_eff,
  tbq_evt_if.sink                 evt,
  output logic                    push,
  output logic [4*COORD_BITS-1:0] push_data,
  input  logic                    q_full
);

  logic                  accept;
  logic                  drag_active;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_y;
  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;

  assign evt.ready = !q_full;
  assign accept    = evt.valid && evt.ready;

  // Saturate the position to the viewport
  assign px = (evt.pos_x > width_eff)  ? width_eff  : evt.pos_x;
  assign py = (evt.pos_y > height_eff) ? height_eff : evt.pos_y;

  // Queue an armed move as {from, to}
  assign push      = accept && (evt.operation == OP_MOVE) && drag_active;
  assign push_data = {last_x, last_y, px, py};

  // Track drag state and last position
  always_ff @(posedge clk) begin
    if (rst) begin
      drag_active <= 1'b0;
      last_x      <= '0;
      last_y      <= '0;
    end else if (accept) begin
      case (evt.operation)
        OP_PRESS: begin
          drag_active <= 1'b1;
          last_x      <= px;
          last_y      <= py;
        end
        OP_RELEASE: begin
          drag_active <= 1'b0;
        end
        OP_MOVE: begin
          if (drag_active) begin
            last_x <= px;
            last_y <= py;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/tbq_back.sv
// Back end: sequencer over a shared bit-serial divider, square root and MAC
// that turns one drag job into a rotation quaternion. Depends on tbq_pkg, tbq_quat_if.

module tbq_back import tbq_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [COORD_BITS-1:0]   width_eff,
  input  logic [COORD_BITS-1:0]   height_eff,
  input  logic                    job_avail,
  input  logic [4*COORD_BITS-1:0] job,
  output logic                    job_take,
  tbq_quat_if.source              quat
);

  localparam int F     = FRAC_BITS;
  localparam int C     = COORD_BITS;
  localparam int VW    = F + 3;
  localparam int PW    = 2 * VW;
  localparam int AW    = PW + 2;
  localparam int DDW   = 2 * F + 3;
  localparam int DW    = (C + F + 1 > 2 * F + 3) ? C + F + 1 : 2 * F + 3;
  localparam int DVW   = (C > F + 2) ? C : F + 2;
  localparam int SW    = 2 * F + 4;
  localparam int RW    = F + 2;
  localparam int DCW   = $clog2(DW + 1);
  localparam int SCW   = $clog2(RW + 1);
  localparam int OSH   = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam int OSL   = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
  localparam int OSH1  = (OSH > 0) ? OSH - 1 : 0;
  localparam int OW    = VW + 4;

  localparam logic signed [AW-1:0]  ONE2   = AW'(1) << (2 * F);
  localparam logic signed [DDW-1:0] ONE2_D = DDW'(1) << (2 * F);
  localparam logic signed [VW-1:0]  ONE_V  = VW'(1) << F;
  localparam logic [AW-1:0]         RND_C  = AW'(1) << (F - 1);
  localparam logic [OW-1:0]         RND_O  = (OSH > 0) ? (OW'(1) << OSH1) : '0;

  // Sequencer
  back_state_t state;
  back_state_t state_next;
  logic        op_wait;
  logic        step_done;
  logic        div_go;
  logic        sq_go;
  logic        mac_go;
  logic        is_mac;
  logic        pt_store;
  logic        pt_sel;
  logic [1:0]  cidx;
  logic [1:0]  vidx;
  logic        job_same;

  // Job and working values
  logic [C-1:0]            x0, y0, x1, y1;
  logic [C-1:0]            cur_x, cur_y;
  logic signed [C+1:0]     dxs, dys;
  logic [C+1:0]            dx_mag, dy_mag;
  logic [VW-1:0]           tx_mag, ty_mag;
  logic [AW-1:0]           acc_mag;
  logic signed [VW-1:0]    tx, ty, ax, ay, az, bx, by, bz;
  logic signed [VW-1:0]    c0, c1, c2, s_r, qw, qv0, qv1, qv2;
  logic [DVW-1:0]          len_r, n_r;
  logic signed [DDW-1:0]   dd;
  logic signed [AW-1:0]    dd_clamp;
  logic                    s2_outside;
  logic [AW-1:0]           cr_q;
  logic signed [VW-1:0]    cr_res;

  // MAC
  logic [1:0]              mac_k, mac_nt;
  logic                    mac_vld, mac_neg, neg_d, mac_issue;
  logic signed [VW-1:0]    ma, mb;
  logic signed [PW-1:0]    prod;
  logic signed [AW-1:0]    acc;

  // Divider
  logic [DW-1:0]           div_quo, div_num;
  logic [DVW-1:0]          div_rem, div_den, div_dsr;
  logic                    div_neg, div_sgn, div_ge, div_done;
  logic [DCW-1:0]          div_cnt;
  logic [DVW:0]            div_sh;
  logic [VW-1:0]           div_q;
  logic signed [VW-1:0]    div_res;

  // Square root
  logic [SW-1:0]           sq_val, sq_in;
  logic [RW+1:0]           sq_rem;
  logic [RW-1:0]           sq_root;
  logic [SCW-1:0]          sq_cnt;
  logic [RW+3:0]           sq_sh, sq_trial;
  logic                    sq_ge, sq_done;
  logic signed [VW-1:0]    sq_res;

  // Output register
  logic                    ovalid;
  logic signed [15:0]      ow, ox, oy, oz;

  function automatic logic [15:0] to_out(input logic signed [VW-1:0] v);
    logic [OW-1:0] mag;
    logic [OW-1:0] r;
    mag = v[VW-1] ? OW'(-v) : OW'(v);
    if (OSH > 0) begin
      r = (mag + RND_O) >> OSH;
    end else begin
      r = mag << OSL;
    end
    if (r > OW'(QUAT_ONE)) begin
      r = OW'(QUAT_ONE);
    end
    to_out = v[VW-1] ? -16'(r) : 16'(r);
  endfunction

  // Unpack the job and pick the point being mapped
  assign x0       = job[4*C-1:3*C];
  assign y0       = job[3*C-1:2*C];
  assign x1       = job[2*C-1:C];
  assign y1       = job[C-1:0];
  assign job_same = (x0 == x1) && (y0 == y1);

  logic [C-1:0] jx0, jy0, jx1, jy1;
  assign cur_x = pt_sel ? jx1 : jx0;
  assign cur_y = pt_sel ? jy1 : jy0;

  // Signed viewport offsets and magnitudes
  assign dxs     = $signed({1'b0, cur_x, 1'b0}) - $signed({2'b00, width_eff});
  assign dys     = $signed({2'b00, height_eff}) - $signed({1'b0, cur_y, 1'b0});
  assign dx_mag  = dxs[C+1] ? (C+2)'(-dxs) : (C+2)'(dxs);
  assign dy_mag  = dys[C+1] ? (C+2)'(-dys) : (C+2)'(dys);
  assign tx_mag  = tx[VW-1] ? VW'(-tx) : VW'(tx);
  assign ty_mag  = ty[VW-1] ? VW'(-ty) : VW'(ty);
  assign acc_mag = acc[AW-1] ? AW'(-acc) : AW'(acc);

  assign s2_outside = (acc > ONE2);
  assign dd_clamp   = (acc > ONE2) ? ONE2 : ((acc < -ONE2) ? -ONE2 : acc);

  // Round a cross term down to F fraction bits, half away from zero
  assign cr_q   = (acc_mag + RND_C) >> F;
  assign cr_res = acc[AW-1] ? -$signed(VW'(cr_q)) : $signed(VW'(cr_q));

  // Divider datapath
  assign div_sh   = {div_rem, div_quo[DW-1]};
  assign div_ge   = (div_sh >= {1'b0, div_den});
  assign div_done = op_wait && (div_cnt == '0);
  assign div_q    = div_quo[VW-1:0];
  assign div_res  = div_neg ? -$signed(div_q) : $signed(div_q);

  // Square-root datapath
  assign sq_sh    = {sq_rem, sq_val[SW-1:SW-2]};
  assign sq_trial = (RW+4)'({sq_root, 2'b01});
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_done  = op_wait && (sq_cnt == '0);
  assign sq_res   = $signed(VW'(sq_root));

  // Select divider operands
  always_comb begin
    div_num = '0;
    div_dsr = '0;
    div_sgn = 1'b0;
    case (state)
      ST_SX: begin
        div_num = (DW'(dx_mag) << F) + DW'(width_eff >> 1);
        div_dsr = DVW'(width_eff);
        div_sgn = dxs[C+1];
      end
      ST_SY: begin
        div_num = (DW'(dy_mag) << F) + DW'(height_eff >> 1);
        div_dsr = DVW'(height_eff);
        div_sgn = dys[C+1];
      end
      ST_SNX: begin
        div_num = (DW'(tx_mag) << F) + DW'(len_r >> 1);
        div_dsr = len_r;
        div_sgn = tx[VW-1];
      end
      ST_SNY: begin
        div_num = (DW'(ty_mag) << F) + DW'(len_r >> 1);
        div_dsr = len_r;
        div_sgn = ty[VW-1];
      end
      ST_VDIV: begin
        div_num = DW'(acc_mag) + DW'(n_r >> 1);
        div_dsr = n_r;
        div_sgn = acc[AW-1];
      end
      default: ;
    endcase
  end

  // Select square-root operand
  always_comb begin
    sq_in = '0;
    case (state)
      ST_SZ:   sq_in = s2_outside ? SW'(acc) : SW'(ONE2 - acc);
      ST_NSQ:  sq_in = SW'(acc);
      ST_SIN:  sq_in = SW'((ONE2_D - dd) >>> 1);
      ST_COS:  sq_in = SW'((ONE2_D + dd) >>> 1);
      default: ;
    endcase
  end

  // Select MAC terms
  always_comb begin
    ma      = '0;
    mb      = '0;
    mac_neg = 1'b0;
    mac_nt  = 2'd0;
    is_mac  = 1'b0;
    case (state)
      ST_S2: begin
        is_mac = 1'b1;
        mac_nt = 2'd2;
        ma     = (mac_k == 2'd0) ? tx : ty;
        mb     = ma;
      end
      ST_DOT: begin
        is_mac = 1'b1;
        mac_nt = 2'd3;
        case (mac_k)
          2'd0:    begin ma = ax; mb = bx; end
          2'd1:    begin ma = ay; mb = by; end
          default: begin ma = az; mb = bz; end
        endcase
      end
      ST_CROSS: begin
        is_mac  = 1'b1;
        mac_nt  = 2'd2;
        mac_neg = (mac_k != 2'd0);
        case (cidx)
          2'd0:    begin ma = mac_neg ? az : ay; mb = mac_neg ? by : bz; end
          2'd1:    begin ma = mac_neg ? ax : az; mb = mac_neg ? bz : bx; end
          default: begin ma = mac_neg ? ay : ax; mb = mac_neg ? bx : by; end
        endcase
      end
      ST_NORM: begin
        is_mac = 1'b1;
        mac_nt = 2'd3;
        case (mac_k)
          2'd0:    ma = c0;
          2'd1:    ma = c1;
          default: ma = c2;
        endcase
        mb = ma;
      end
      ST_VEC: begin
        is_mac = 1'b1;
        mac_nt = 2'd1;
        ma     = s_r;
        case (vidx)
          2'd0:    mb = c0;
          2'd1:    mb = c1;
          default: mb = c2;
        endcase
      end
      default: ;
    endcase
  end

  assign mac_go    = is_mac && !op_wait;
  assign mac_issue = is_mac && op_wait && (mac_k != mac_nt);

  // Next state and unit launches
  always_comb begin
    state_next = state;
    step_done  = 1'b0;
    job_take   = 1'b0;
    div_go     = 1'b0;
    sq_go      = 1'b0;
    pt_store   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (job_avail) begin
          job_take   = 1'b1;
          state_next = job_same ? ST_OUT : ST_SX;
        end
      end
      ST_SX, ST_SY, ST_SNX, ST_SNY, ST_VDIV: begin
        div_go = !op_wait;
        if (div_done) begin
          step_done = 1'b1;
          case (state)
            ST_SX:  state_next = ST_SY;
            ST_SY:  state_next = ST_S2;
            ST_SNX: state_next = ST_SNY;
            ST_SNY: begin
              pt_store   = 1'b1;
              state_next = pt_sel ? ST_DOT : ST_SX;
            end
            default: state_next = (vidx == 2'd2) ? ST_OUT : ST_VEC;
          endcase
        end
      end
      ST_SZ, ST_NSQ, ST_SIN, ST_COS: begin
        sq_go = !op_wait;
        if (sq_done) begin
          step_done = 1'b1;
          case (state)
            ST_SZ: begin
              if (s2_outside) begin
                state_next = ST_SNX;
              end else begin
                pt_store   = 1'b1;
                state_next = pt_sel ? ST_DOT : ST_SX;
              end
            end
            ST_NSQ:  state_next = (sq_root == '0) ? ST_OUT : ST_SIN;
            ST_SIN:  state_next = ST_COS;
            default: state_next = ST_VEC;
          endcase
        end
      end
      ST_S2, ST_DOT, ST_CROSS, ST_NORM, ST_VEC: begin
        if (op_wait && (mac_k == mac_nt) && !mac_vld) begin
          step_done = 1'b1;
          case (state)
            ST_S2:    state_next = ST_SZ;
            ST_DOT:   state_next = ST_CROSS;
            ST_CROSS: state_next = (cidx == 2'd2) ? ST_NORM : ST_CROSS;
            ST_NORM:  state_next = ST_NSQ;
            default:  state_next = ST_VDIV;
          endcase
        end
      end
      ST_OUT: begin
        if (!ovalid || quat.ready) begin
          step_done  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      op_wait <= 1'b0;
      mac_k   <= '0;
      mac_vld <= 1'b0;
      div_cnt <= '0;
      sq_cnt  <= '0;
      pt_sel  <= 1'b0;
      cidx    <= '0;
      vidx    <= '0;
      ovalid  <= 1'b0;
    end else begin
      if (step_done) begin
        op_wait <= 1'b0;
      end else if (div_go || sq_go || mac_go) begin
        op_wait <= 1'b1;
      end
      if (mac_go) begin
        mac_k   <= '0;
        mac_vld <= 1'b0;
      end else if (mac_issue) begin
        mac_k   <= mac_k + 1'b1;
        mac_vld <= 1'b1;
      end else begin
        mac_vld <= 1'b0;
      end
      if (div_go) begin
        div_cnt <= DCW'(DW);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (sq_go) begin
        sq_cnt <= SCW'(RW);
      end else if (sq_cnt != '0) begin
        sq_cnt <= sq_cnt - 1'b1;
      end
      if (job_take) begin
        pt_sel <= 1'b0;
        cidx   <= '0;
        vidx   <= '0;
      end else begin
        if (pt_store) begin
          pt_sel <= 1'b1;
        end
        if (step_done && (state == ST_CROSS)) begin
          cidx <= cidx + 1'b1;
        end
        if (step_done && (state == ST_VDIV)) begin
          vidx <= vidx + 1'b1;
        end
      end
      if (quat.ready) begin
        ovalid <= 1'b0;
      end
      if (step_done && (state == ST_OUT)) begin
        ovalid <= 1'b1;
      end
    end
  end

  // Run the arithmetic units and capture results
  always_ff @(posedge clk) begin
    // divider: one quotient bit per cycle
    if (div_go) begin
      div_rem <= '0;
      div_quo <= div_num;
      div_den <= div_dsr;
      div_neg <= div_sgn;
    end else if (div_cnt != '0) begin
      div_rem <= div_ge ? DVW'(div_sh - {1'b0, div_den}) : DVW'(div_sh);
      div_quo <= {div_quo[DW-2:0], div_ge};
    end

    // square root: one root bit per cycle
    if (sq_go) begin
      sq_rem  <= '0;
      sq_root <= '0;
      sq_val  <= sq_in;
    end else if (sq_cnt != '0) begin
      sq_rem  <= sq_ge ? (RW+2)'(sq_sh - sq_trial) : (RW+2)'(sq_sh);
      sq_root <= {sq_root[RW-2:0], sq_ge};
      sq_val  <= sq_val << 2;
    end

    // mac: product register, then accumulate
    if (mac_go) begin
      acc <= '0;
    end else begin
      if (mac_issue) begin
        prod  <= ma * mb;
        neg_d <= mac_neg;
      end
      if (mac_vld) begin
        acc <= neg_d ? acc - AW'(prod) : acc + AW'(prod);
      end
    end

    // load a job; identical endpoints give the identity
    if (job_take) begin
      jx0 <= x0;
      jy0 <= y0;
      jx1 <= x1;
      jy1 <= y1;
      qw  <= ONE_V;
      qv0 <= '0;
      qv1 <= '0;
      qv2 <= '0;
    end

    if (step_done) begin
      case (state)
        ST_SX:  tx <= div_res;
        ST_SY:  ty <= div_res;
        ST_SNX: tx <= div_res;
        ST_SNY: begin
          if (pt_sel) begin
            bx <= tx; by <= div_res; bz <= '0;
          end else begin
            ax <= tx; ay <= div_res; az <= '0;
          end
        end
        ST_SZ: begin
          if (s2_outside) begin
            len_r <= DVW'(sq_root);
          end else if (pt_sel) begin
            bx <= tx; by <= ty; bz <= sq_res;
          end else begin
            ax <= tx; ay <= ty; az <= sq_res;
          end
        end
        ST_DOT: dd <= DDW'(dd_clamp);
        ST_CROSS: begin
          case (cidx)
            2'd0:    c0 <= cr_res;
            2'd1:    c1 <= cr_res;
            default: c2 <= cr_res;
          endcase
        end
        ST_NSQ:  n_r <= DVW'(sq_root);
        ST_SIN:  s_r <= sq_res;
        ST_COS:  qw  <= sq_res;
        ST_VDIV: begin
          case (vidx)
            2'd0:    qv0 <= div_res;
            2'd1:    qv1 <= div_res;
            default: qv2 <= div_res;
          endcase
        end
        ST_OUT: begin
          ow <= to_out(qw);
          ox <= to_out(qv0);
          oy <= to_out(qv1);
          oz <= to_out(qv2);
        end
        default: ;
      endcase
    end
  end

  assign quat.valid  = ovalid;
  assign quat.quat_w = ow;
  assign quat.quat_x = ox;
  assign quat.quat_y = oy;
  assign quat.quat_z = oz;

  // Divider and square root never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    (div_cnt != '0) |-> (sq_cnt == '0))
    else $error("divider and square root busy at once");

  // A zero cross norm must have taken the identity path
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIN) |-> (n_r != '0))
    else $error("sine step reached with zero cross norm");

  // Taking a job always starts work or goes straight to output
  a_take_dispatch: assert property (@(posedge clk) disable iff (rst)
    job_take |=> (state == ST_OUT || state == ST_SX))
    else $error("job taken without dispatch");

  // The w and x results stay within unit range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (ow <= 16'sd16384 && ow >= -16'sd16384 &&
                ox <= 16'sd16384 && ox >= -16'sd16384))
    else $error("quaternion word out of range");

endmodule

FILE: rtl/core/trackball_drag_quaternion_unit.sv
// Top level: APB register file, event front end, job queue, quaternion back end.
// Press, release and unarmed moves give no word.
// An armed move gives one word; identical positions go straight to output and a
// zero cross product skips the sine and vector steps. The back end takes a new
// move only when done with the last (the queue holds the rest), and its pace is
// set by the shared bit-serial divider.
// Reset (rst, synchronous): drag disarmed, last position zero, viewport 640x480.

module trackball_drag_quaternion_unit import tbq_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tbq_evt_if.sink     evt,
  tbq_quat_if.source  quat
);

  localparam int JOB_BITS = 4 * COORD_BITS;

  logic [COORD_BITS-1:0] view_width;
  logic [COORD_BITS-1:0] view_height;
  logic [COORD_BITS-1:0] width_eff;
  logic [COORD_BITS-1:0] height_eff;
  logic                  cfg_wr;
  logic                  push;
  logic [JOB_BITS-1:0]   push_data;
  logic                  q_full;
  logic                  q_empty;
  logic                  job_take;
  logic [JOB_BITS-1:0]   job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write viewport registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view_width  <= COORD_BITS'(WIDTH_RST);
      view_height <= COORD_BITS'(HEIGHT_RST);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH:  view_width  <= pwdata[COORD_BITS-1:0];
        REG_HEIGHT: view_height <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(view_height) : 32'(view_width);

  // Treat a zero viewport size as one
  assign width_eff  = (view_width  == '0) ? COORD_BITS'(1) : view_width;
  assign height_eff = (view_height == '0) ? COORD_BITS'(1) : view_height;

  tbq_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .evt        (evt),
    .push       (push),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  tbq_queue #(
    .WORD_BITS (JOB_BITS),
    .DEPTH     (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (job_take),
    .pop_data  (job),
    .empty     (q_empty)
  );

  tbq_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .job_avail  (!q_empty),
    .job        (job),
    .job_take   (job_take),
    .quat       (quat)
  );

endmodule
